// File: hdl/bpc_pkg.sv
`timescale 1ns / 1ps

package bpc_pkg;

   localparam int RAW_W   = 24;
   localparam int CAL_W   = 16;
   localparam int TEMP_W  = 19;
   localparam int PRESS_W = 32;
   localparam int WIDE_W  = 40;

   // accept edge to result strobe edge
   localparam int LATENCY = 11;

   localparam logic signed [TEMP_W-1:0] T_REF = 19'sd2000;
   localparam logic signed [TEMP_W-1:0] T_LOW = -19'sd1500;

   typedef enum logic [2:0] {
      CSR_PRESS_SENS   = 3'd0,
      CSR_PRESS_OFF    = 3'd1,
      CSR_SENS_TC      = 3'd2,
      CSR_OFF_TC       = 3'd3,
      CSR_REF_TEMP     = 3'd4,
      CSR_TEMP_TC      = 3'd5
   } csr_index_type;

   typedef struct packed {
      logic [CAL_W-1:0] press_sens;
      logic [CAL_W-1:0] press_off;
      logic [CAL_W-1:0] sens_tc;
      logic [CAL_W-1:0] off_tc;
      logic [CAL_W-1:0] ref_temp;
      logic [CAL_W-1:0] temp_tc;
   } cal_type;

   // first-order terms
   typedef struct packed {
      logic signed [TEMP_W-1:0] t1;
      logic [17:0]              t2;
      logic signed [WIDE_W-1:0] off;
      logic signed [WIDE_W-1:0] sens;
      logic [RAW_W-1:0]         d1;
   } first_type;

   // after second-order correction
   typedef struct packed {
      logic signed [TEMP_W-1:0] temp;
      logic signed [WIDE_W-1:0] off;
      logic signed [WIDE_W-1:0] sens;
      logic [RAW_W-1:0]         d1;
   } corr_type;

endpackage

// File: hdl/bpc_first.sv
`timescale 1ns / 1ps

module bpc_first (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  logic [bpc_pkg::RAW_W-1:0]     raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]     raw_temperature,
   input  bpc_pkg::cal_type              cal,
   output logic                          out_valid,
   output bpc_pkg::first_type            out_data
);

   // stage 1: temperature delta
   logic signed [24:0] dt_in, dt_ff;
   logic [bpc_pkg::RAW_W-1:0] d1a_ff, d1b_ff;
   logic v1_ff, v2_ff, v3_ff;

   // stage 2: products
   logic signed [41:0] m6_in, m6_ff;
   logic signed [41:0] m4_in, m4_ff;
   logic signed [41:0] m3_in, m3_ff;
   logic signed [49:0] sq_in, sq_ff;

   // stage 3: first-order terms
   logic signed [41:0] t_div, off_div, sens_div;
   bpc_pkg::first_type first_in, first_ff;

   assign dt_in = $signed({1'b0, raw_temperature}) - $signed({1'b0, cal.ref_temp, 8'h00});

   assign m6_in = 42'(dt_ff) * 42'($signed({1'b0, cal.temp_tc}));
   assign m4_in = 42'(dt_ff) * 42'($signed({1'b0, cal.off_tc}));
   assign m3_in = 42'(dt_ff) * 42'($signed({1'b0, cal.sens_tc}));
   assign sq_in = 50'(dt_ff) * 50'(dt_ff);

   // truncate toward zero
   assign t_div    = (m6_ff + (m6_ff[41] ? 42'sd8388607 : 42'sd0)) >>> 23;
   assign off_div  = (m4_ff + (m4_ff[41] ? 42'sd127 : 42'sd0)) >>> 7;
   assign sens_div = (m3_ff + (m3_ff[41] ? 42'sd255 : 42'sd0)) >>> 8;

   always_comb begin
      first_in.t1   = bpc_pkg::T_REF + $signed(t_div[18:0]);
      first_in.t2   = sq_ff[48:31];
      first_in.off  = $signed({8'h00, cal.press_off, 16'h0000}) + $signed(off_div[39:0]);
      first_in.sens = $signed({9'h000, cal.press_sens, 15'h0000}) + $signed(sens_div[39:0]);
      first_in.d1   = d1b_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
      end
   end

   always_ff @(posedge clock) begin
      dt_ff    <= dt_in;
      d1a_ff   <= raw_pressure;
      m6_ff    <= m6_in;
      m4_ff    <= m4_in;
      m3_ff    <= m3_in;
      sq_ff    <= sq_in;
      d1b_ff   <= d1a_ff;
      first_ff <= first_in;
   end

   assign out_valid = v3_ff;
   assign out_data  = first_ff;

endmodule

// File: hdl/bpc_second.sv
`timescale 1ns / 1ps

module bpc_second (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  in_valid,
   input  bpc_pkg::first_type    in_data,
   output logic                  out_valid,
   output bpc_pkg::corr_type     out_data
);

   // stage 4: squared deltas and range flags
   logic signed [bpc_pkg::TEMP_W-1:0] a_w, b_w;
   logic signed [37:0] asq, bsq;
   logic [35:0] a2_ff, b2_ff;
   logic lt_in, lt_ff, lm_in, lm_ff;
   bpc_pkg::first_type f4_ff;
   logic v4_ff, v5_ff, v6_ff;

   // stage 5: correction sums
   logic [39:0] a5, b7, b11;
   logic [39:0] off2_in, off2_ff, sens2_in, sens2_ff;
   logic signed [bpc_pkg::TEMP_W-1:0] temp_in, temp_ff;
   logic signed [bpc_pkg::WIDE_W-1:0] off5_ff, sens5_ff;
   logic [bpc_pkg::RAW_W-1:0] d15_ff;

   // stage 6: corrected terms
   bpc_pkg::corr_type corr_in, corr_ff;

   assign a_w   = in_data.t1 - bpc_pkg::T_REF;
   assign b_w   = in_data.t1 - bpc_pkg::T_LOW;
   assign asq   = 38'(a_w) * 38'(a_w);
   assign bsq   = 38'(b_w) * 38'(b_w);
   assign lt_in = in_data.t1 < bpc_pkg::T_REF;
   assign lm_in = in_data.t1 < bpc_pkg::T_LOW;

   assign a5  = 40'({a2_ff, 2'b00}) + 40'(a2_ff);
   assign b7  = 40'({b2_ff, 3'b000}) - 40'(b2_ff);
   assign b11 = 40'({b2_ff, 3'b000}) + 40'({b2_ff, 1'b0}) + 40'(b2_ff);

   assign off2_in  = (lt_ff ? (a5 >> 1) : 40'd0) + (lm_ff ? b7 : 40'd0);
   assign sens2_in = (lt_ff ? (a5 >> 2) : 40'd0) + (lm_ff ? (b11 >> 1) : 40'd0);
   assign temp_in  = f4_ff.t1 - (lt_ff ? $signed({1'b0, f4_ff.t2}) : 19'sd0);

   always_comb begin
      corr_in.temp = temp_ff;
      corr_in.off  = off5_ff - $signed(off2_ff);
      corr_in.sens = sens5_ff - $signed(sens2_ff);
      corr_in.d1   = d15_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v4_ff <= 1'b0;
         v5_ff <= 1'b0;
         v6_ff <= 1'b0;
      end else begin
         v4_ff <= in_valid;
         v5_ff <= v4_ff;
         v6_ff <= v5_ff;
      end
   end

   always_ff @(posedge clock) begin
      a2_ff    <= asq[35:0];
      b2_ff    <= bsq[35:0];
      lt_ff    <= lt_in;
      lm_ff    <= lm_in;
      f4_ff    <= in_data;
      off2_ff  <= off2_in;
      sens2_ff <= sens2_in;
      temp_ff  <= temp_in;
      off5_ff  <= f4_ff.off;
      sens5_ff <= f4_ff.sens;
      d15_ff   <= f4_ff.d1;
      corr_ff  <= corr_in;
   end

   assign out_valid = v6_ff;
   assign out_data  = corr_ff;

endmodule

// File: hdl/bpc_press.sv
`timescale 1ns / 1ps

module bpc_press (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 in_valid,
   input  bpc_pkg::corr_type                    in_data,
   output logic                                 out_valid,
   output logic signed [bpc_pkg::TEMP_W-1:0]    out_temperature,
   output logic [bpc_pkg::PRESS_W-1:0]          out_pressure
);

   // stage 7: split multiply, low and high halves of sens
   logic [43:0] plo_in, plo_ff;
   logic signed [44:0] phi_in, phi_ff;
   logic signed [bpc_pkg::WIDE_W-1:0] off7_ff, off8_ff, off9_ff;
   logic signed [bpc_pkg::TEMP_W-1:0] temp7_ff, temp8_ff, temp9_ff, temp10_ff;
   logic v7_ff, v8_ff, v9_ff, v10_ff, v11_ff;

   // stage 8: full product
   logic signed [63:0] prod_in, prod_ff;

   // stage 9: scale by 2^21
   logic signed [63:0] prod_div;
   logic signed [43:0] div21_ff;

   // stage 10: subtract offset
   logic signed [44:0] q_in, q_ff;

   // stage 11: scale by 2^15, output register
   logic signed [44:0] q_div;
   logic [bpc_pkg::PRESS_W-1:0] press_in, press_ff;
   logic signed [bpc_pkg::TEMP_W-1:0] temp_out_ff;
   logic load_out;

   assign plo_in = {20'h00000, in_data.d1} * {24'h000000, in_data.sens[19:0]};
   assign phi_in = 45'($signed({1'b0, in_data.d1})) * 45'($signed(in_data.sens[39:20]));

   assign prod_in = (64'(phi_ff) <<< 20) + $signed({20'h00000, plo_ff});

   // truncate toward zero
   assign prod_div = (prod_ff + (prod_ff[63] ? 64'sd2097151 : 64'sd0)) >>> 21;
   assign q_in     = 45'(div21_ff) - 45'(off9_ff);
   assign q_div    = (q_ff + (q_ff[44] ? 45'sd32767 : 45'sd0)) >>> 15;
   assign press_in = q_div[31:0];

   assign load_out = v10_ff && !reset;

   always_ff @(posedge clock) begin
      if (reset) begin
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
      end else begin
         v7_ff  <= in_valid;
         v8_ff  <= v7_ff;
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
      end
   end

   always_ff @(posedge clock) begin
      plo_ff    <= plo_in;
      phi_ff    <= phi_in;
      off7_ff   <= in_data.off;
      temp7_ff  <= in_data.temp;
      prod_ff   <= prod_in;
      off8_ff   <= off7_ff;
      temp8_ff  <= temp7_ff;
      div21_ff  <= prod_div[43:0];
      off9_ff   <= off8_ff;
      temp9_ff  <= temp8_ff;
      q_ff      <= q_in;
      temp10_ff <= temp9_ff;
   end

   // result fields change only with a strobe
   always_ff @(posedge clock) begin
      if (reset) begin
         press_ff    <= '0;
         temp_out_ff <= '0;
      end else if (load_out) begin
         press_ff    <= press_in;
         temp_out_ff <= temp10_ff;
      end
   end

   assign out_valid       = v11_ff;
   assign out_temperature = temp_out_ff;
   assign out_pressure    = press_ff;

endmodule

// File: hdl/barometric_pressure_compensation_top.sv
`timescale 1ns / 1ps

// Second-order compensated barometer: each transaction takes a raw 24-bit pressure and a raw
// 24-bit temperature conversion and returns the temperature in hundredths of a degree C (19-bit
// two's complement) and the pressure in pascals (low 32 bits). The datapath is an 11-stage
// pipeline that never stalls, so a new transaction is taken
// every clock cycle and its result is strobed on rsp_valid for one cycle once it leaves the final
// stage register; busy is high only during reset. Results are never held back, the receiver
// must take each one as it is strobed. The six 16-bit calibration words sit at csr indexes 0 to
// 5, reset to zero, csr_ready is always high, writes to other indexes are dropped, and they may
// be rewritten only while no transaction is in flight.
module barometric_pressure_compensation_top (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 start,
   output logic                                 busy,
   input  logic [bpc_pkg::RAW_W-1:0]            req_raw_pressure,
   input  logic [bpc_pkg::RAW_W-1:0]            req_raw_temperature,
   output logic                                 rsp_valid,
   output logic signed [bpc_pkg::TEMP_W-1:0]    rsp_temperature,
   output logic [bpc_pkg::PRESS_W-1:0]          rsp_pressure,
   input  logic                                 csr_valid,
   output logic                                 csr_ready,
   input  logic [2:0]                           csr_index,
   input  logic [bpc_pkg::CAL_W-1:0]            csr_data
);

   bpc_pkg::cal_type   cal_ff;
   bpc_pkg::first_type first_data;
   bpc_pkg::corr_type  corr_data;
   logic first_valid, corr_valid;
   logic accept;

   assign busy      = reset;
   assign csr_ready = 1'b1;
   assign accept    = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         cal_ff <= '0;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            bpc_pkg::CSR_PRESS_SENS: begin
               cal_ff.press_sens <= csr_data;
            end
            bpc_pkg::CSR_PRESS_OFF: begin
               cal_ff.press_off <= csr_data;
            end
            bpc_pkg::CSR_SENS_TC: begin
               cal_ff.sens_tc <= csr_data;
            end
            bpc_pkg::CSR_OFF_TC: begin
               cal_ff.off_tc <= csr_data;
            end
            bpc_pkg::CSR_REF_TEMP: begin
               cal_ff.ref_temp <= csr_data;
            end
            bpc_pkg::CSR_TEMP_TC: begin
               cal_ff.temp_tc <= csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   bpc_first u_first (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (accept),
      .raw_pressure    (req_raw_pressure),
      .raw_temperature (req_raw_temperature),
      .cal             (cal_ff),
      .out_valid       (first_valid),
      .out_data        (first_data)
   );

   bpc_second u_second (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (first_valid),
      .in_data   (first_data),
      .out_valid (corr_valid),
      .out_data  (corr_data)
   );

   bpc_press u_press (
      .clock           (clock),
      .reset           (reset),
      .in_valid        (corr_valid),
      .in_data         (corr_data),
      .out_valid       (rsp_valid),
      .out_temperature (rsp_temperature),
      .out_pressure    (rsp_pressure)
   );

endmodule

// File: hdl/bpc_checker.sv
`timescale 1ns / 1ps

module bpc_checker (
   input logic                                 clock,
   input logic                                 reset,
   input logic                                 start,
   input logic                                 busy,
   input logic                                 rsp_valid,
   input logic signed [bpc_pkg::TEMP_W-1:0]    rsp_temperature,
   input logic [bpc_pkg::PRESS_W-1:0]          rsp_pressure
);

   // every accepted transaction gives a strobe after the fixed latency
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(bpc_pkg::LATENCY) rsp_valid)
      else $error("accepted transaction produced no result");

   // no strobe without a transaction accepted at the matching edge
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(start && !busy, bpc_pkg::LATENCY))
      else $error("result without a matching transaction");

   // result fields move only together with a strobe
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> ($stable(rsp_temperature) && $stable(rsp_pressure)))
      else $error("result fields changed without a strobe");

endmodule

bind barometric_pressure_compensation_top bpc_checker u_bpc_checker (
   .clock           (clock),
   .reset           (reset),
   .start           (start),
   .busy            (busy),
   .rsp_valid       (rsp_valid),
   .rsp_temperature (rsp_temperature),
   .rsp_pressure    (rsp_pressure)
);
